>>> src/bmhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhs_pkg
// Shared types, codes and helpers for the bitmap with highest-set tracking.
// ----------------------------------------------------------------------------
package bmhs_pkg;

    // Request codes on req_type
    typedef enum logic [2:0] {
        REQ_SET       = 3'd0,
        REQ_CLEAR     = 3'd1,
        REQ_TEST      = 3'd2,
        REQ_FILL      = 3'd3,
        REQ_CLR_ALL   = 3'd4,
        REQ_CLR_ABOVE = 3'd5
    } req_t;

    // What the controller has to run for the latched request
    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_BIT       = 3'd1,
        KIND_FILL      = 3'd2,
        KIND_CLR_ALL   = 3'd3,
        KIND_CLR_ABOVE = 3'd4
    } kind_t;

    typedef struct packed {
        logic load;       // latch the request
        logic rd_target;  // read the addressed byte
        logic modify;     // write back the modified byte
        logic sweep;      // write one byte of a fill/clear sweep
        logic scan;       // one step of the downward scan
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  rmw_needed;   // clear-above: boundary byte lies inside the store
        logic  sweep_empty;  // clear-above: nothing above the boundary byte
        logic  sweep_last;
        logic  rescan;       // cleared bit was the highest
        logic  scan_done;
    } status_t;

    // 1-based position of the top set bit of a byte, 0 if none
    function automatic logic [3:0] top_in_byte(input logic [7:0] b);
        logic [3:0] res;
        res = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                res = 4'(k + 1);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> src/bmhs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhs_ctrl
// Sequencer: decodes the latched request and steps read-modify-write,
// sweep and downward scan in the datapath.
// ----------------------------------------------------------------------------
module bmhs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bmhs_pkg::status_t status,
    output logic                   busy,
    output logic                   done,
    output bmhs_pkg::cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DEC   = 6'b000010,
        ST_RD    = 6'b000100,
        ST_MOD   = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_SCAN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   resp_reg;
    logic   resp_next;

    always_comb
    begin
        state_next = state_reg;
        resp_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !resp_reg)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                unique case (status.kind)
                    bmhs_pkg::KIND_BIT:
                    begin
                        state_next = ST_RD;
                    end
                    bmhs_pkg::KIND_FILL, bmhs_pkg::KIND_CLR_ALL:
                    begin
                        state_next = ST_SWEEP;
                    end
                    bmhs_pkg::KIND_CLR_ABOVE:
                    begin
                        state_next = status.rmw_needed ? ST_RD : ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        resp_next  = 1'b1;
                    end
                endcase
            end
            ST_RD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (status.kind == bmhs_pkg::KIND_CLR_ABOVE)
                begin
                    state_next = status.sweep_empty ? ST_SCAN : ST_SWEEP;
                end
                else if (status.rescan)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                    resp_next  = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    if (status.kind == bmhs_pkg::KIND_CLR_ABOVE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        resp_next  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_IDLE;
                    resp_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            resp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // The result cycle also blocks a new request
    assign busy = (state_reg != ST_IDLE) || resp_reg;
    assign done = resp_reg;

    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && start && !resp_reg;
        cmd.rd_target = (state_reg == ST_RD);
        cmd.modify    = (state_reg == ST_MOD);
        cmd.sweep     = (state_reg == ST_SWEEP);
        cmd.scan      = (state_reg == ST_SCAN);
    end

`ifndef SYNTH
    a_done_then_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && (state_reg == ST_IDLE))
        else $error("result strobe not followed by idle");

    a_scan_exits_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && status.scan_done |=> done)
        else $error("scan finished without a result");

    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DEC) && busy)
        else $error("accepted request did not enter decode");
`endif

endmodule
`default_nettype wire

>>> src/bmhs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhs_datapath
// Byte store, request registers, highest-set register and the sweep/scan
// address counters.
// ----------------------------------------------------------------------------
module bmhs_datapath #(
    parameter int MAX_BYTES = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [2:0]     req_type,
    input  wire logic [8:0]     position,
    input  wire logic           cfg_we,
    input  wire logic [5:0]     bytes_in_use,
    input  wire bmhs_pkg::cmd_t cmd,
    output bmhs_pkg::status_t   status,
    output logic                bit_was_set,
    output logic [8:0]          highest_set,
    output logic                range_error
);

    localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int SW   = $clog2(MAX_BYTES + 1);
    localparam int HWR  = $clog2(8 * MAX_BYTES + 1);
    localparam int HW   = (HWR > 9) ? HWR : 9;

    // Configuration
    logic [5:0] bytes_in_use_reg;

    // Request registers
    bmhs_pkg::kind_t kind_reg;
    bmhs_pkg::req_t  op_reg;
    logic            err_reg;
    logic            was_reg;
    logic [8:0]      pos_reg;
    logic [AW-1:0]   byte_reg;
    logic [2:0]      bit_reg;
    logic [SW-1:0]   full_reg;
    logic [7:0]      low_reg;

    logic [SW-1:0]   sweep_idx_reg;
    logic [AW-1:0]   scan_idx_reg;
    logic [AW-1:0]   chk_idx_reg;
    logic            chk_vld_reg;
    logic [HW-1:0]   highest_reg;

    // Store
    logic [7:0]            mem [0:MAX_BYTES-1];
    logic [MAX_BYTES-1:0]  vld_reg;
    logic [7:0]            rd_byte_reg;

    // Request decode
    logic [5:0]      eff;
    logic [8:0]      limit;
    logic [8:0]      pm1;
    logic [5:0]      full6;
    logic [SW-1:0]   full_in;
    logic            in_err;
    bmhs_pkg::kind_t kind_in;

    always_comb
    begin
        if ((MAX_BYTES < 64) && (bytes_in_use_reg > 6'(MAX_BYTES)))
        begin
            eff = 6'(MAX_BYTES);
        end
        else
        begin
            eff = bytes_in_use_reg;
        end
        limit   = {eff, 3'b000};
        pm1     = position - 9'd1;
        full6   = position[8:3];
        full_in = SW'(full6);
        in_err  = 1'b0;
        kind_in = bmhs_pkg::KIND_NONE;
        unique case (bmhs_pkg::req_t'(req_type))
            bmhs_pkg::REQ_SET, bmhs_pkg::REQ_CLEAR, bmhs_pkg::REQ_TEST:
            begin
                in_err  = (position == 9'd0) || (position > limit);
                kind_in = bmhs_pkg::KIND_BIT;
            end
            bmhs_pkg::REQ_FILL:
            begin
                in_err  = (position > limit);
                kind_in = bmhs_pkg::KIND_FILL;
            end
            bmhs_pkg::REQ_CLR_ALL:
            begin
                kind_in = bmhs_pkg::KIND_CLR_ALL;
            end
            bmhs_pkg::REQ_CLR_ABOVE:
            begin
                in_err  = (position > limit);
                kind_in = bmhs_pkg::KIND_CLR_ABOVE;
            end
            default:
            begin
                kind_in = bmhs_pkg::KIND_NONE;
            end
        endcase
        if (in_err)
        begin
            kind_in = bmhs_pkg::KIND_NONE;
        end
    end

    // Modify and sweep data
    logic [7:0]    mask;
    logic [7:0]    mod_wdata;
    logic          mod_we;
    logic [7:0]    sweep_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          rd_nz;
    logic [3:0]    rd_top;
    logic [HW-1:0] hit_pos;

    always_comb
    begin
        mask = 8'd1 << bit_reg;
        case (op_reg)
            bmhs_pkg::REQ_SET:   mod_wdata = rd_byte_reg | mask;
            bmhs_pkg::REQ_CLEAR: mod_wdata = rd_byte_reg & ~mask;
            default:             mod_wdata = rd_byte_reg & low_reg;
        endcase
        mod_we = (kind_reg == bmhs_pkg::KIND_CLR_ABOVE) ||
                 ((kind_reg == bmhs_pkg::KIND_BIT) && (op_reg != bmhs_pkg::REQ_TEST));

        sweep_wdata = 8'h00;
        if (kind_reg == bmhs_pkg::KIND_FILL)
        begin
            if (sweep_idx_reg < full_reg)
            begin
                sweep_wdata = 8'hFF;
            end
            else if (sweep_idx_reg == full_reg)
            begin
                sweep_wdata = low_reg;
            end
        end

        if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(sweep_idx_reg);
            mem_wdata = sweep_wdata;
        end
        else
        begin
            mem_we    = cmd.modify && mod_we;
            mem_waddr = byte_reg;
            mem_wdata = mod_wdata;
        end
        mem_raddr = cmd.scan ? scan_idx_reg : byte_reg;

        rd_nz   = (rd_byte_reg != 8'd0);
        rd_top  = bmhs_pkg::top_in_byte(rd_byte_reg);
        hit_pos = HW'({chk_idx_reg, 3'b000}) + HW'(rd_top);

        status.kind        = kind_reg;
        status.rmw_needed  = (full_reg < SW'(MAX_BYTES));
        status.sweep_empty = (full_reg >= SW'(MAX_BYTES - 1));
        status.sweep_last  = (sweep_idx_reg == SW'(MAX_BYTES - 1));
        status.rescan      = (kind_reg == bmhs_pkg::KIND_BIT) &&
                             (op_reg == bmhs_pkg::REQ_CLEAR) &&
                             (HW'(pos_reg) == highest_reg);
        status.scan_done   = chk_vld_reg && (rd_nz || (chk_idx_reg == '0));
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_byte_reg <= vld_reg[mem_raddr] ? mem[mem_raddr] : 8'h00;
    end

    // Payload of the latched request and the address counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= bmhs_pkg::req_t'(req_type);
            pos_reg  <= position;
            bit_reg  <= pm1[2:0];
            full_reg <= full_in;
            low_reg  <= ~(8'hFF << position[2:0]);
            if (kind_in == bmhs_pkg::KIND_CLR_ABOVE)
            begin
                byte_reg      <= AW'(full6);
                sweep_idx_reg <= SW'(full_in + SW'(1));
                if (full_in < SW'(MAX_BYTES))
                begin
                    scan_idx_reg <= AW'(full6);
                end
                else
                begin
                    scan_idx_reg <= AW'(MAX_BYTES - 1);
                end
            end
            else
            begin
                byte_reg      <= AW'(pm1[8:3]);
                sweep_idx_reg <= '0;
                scan_idx_reg  <= AW'(pm1[8:3]);
            end
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_idx_reg <= sweep_idx_reg + SW'(1);
            end
            if (cmd.scan && (scan_idx_reg != '0))
            begin
                scan_idx_reg <= scan_idx_reg - AW'(1);
            end
        end
        chk_idx_reg <= scan_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_use_reg <= 6'd32;
            kind_reg         <= bmhs_pkg::KIND_NONE;
            err_reg          <= 1'b0;
            was_reg          <= 1'b0;
            chk_vld_reg      <= 1'b0;
            highest_reg      <= '0;
            vld_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bytes_in_use_reg <= bytes_in_use;
            end
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            // Hold the check flag low outside a scan so a new scan starts clean
            chk_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                kind_reg <= kind_in;
                err_reg  <= in_err;
                was_reg  <= 1'b0;
                if (kind_in == bmhs_pkg::KIND_FILL)
                begin
                    highest_reg <= HW'(position);
                end
                else if (kind_in == bmhs_pkg::KIND_CLR_ALL)
                begin
                    highest_reg <= '0;
                end
            end
            if (cmd.modify && (kind_reg == bmhs_pkg::KIND_BIT))
            begin
                was_reg <= (rd_byte_reg & mask) != 8'd0;
                if ((op_reg == bmhs_pkg::REQ_SET) && (HW'(pos_reg) > highest_reg))
                begin
                    highest_reg <= HW'(pos_reg);
                end
            end
            if (cmd.scan && status.scan_done)
            begin
                highest_reg <= rd_nz ? hit_pos : '0;
            end
        end
    end

    assign bit_was_set = was_reg;
    assign highest_set = highest_reg[8:0];
    assign range_error = err_reg;

`ifndef SYNTH
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd_target, cmd.modify, cmd.sweep, cmd.scan}))
        else $error("more than one datapath command at once");

    a_highest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        highest_reg <= HW'(8 * MAX_BYTES))
        else $error("highest position beyond the store");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> (sweep_idx_reg < SW'(MAX_BYTES)))
        else $error("sweep address beyond the store");

    a_error_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !was_reg && (kind_reg == bmhs_pkg::KIND_NONE))
        else $error("rejected request reported a bit or ran an operation");
`endif

endmodule
`default_nettype wire

>>> src/bitmap_with_highest_set_tracking.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_with_highest_set_tracking
// Byte-organised bitmap with 1-based positions that keeps the highest set
// position; set, clear, test, fill-first-N, clear-all and clear-above-N.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | start / busy       | req_type[2:0], position[8:0]
//  result    | done (1 cycle)     | bit_was_set, highest_set[8:0], range_error
//  config    | cfg_we             | bytes_in_use[5:0]
//
//  A request is taken when start is high and busy low; one result per request.
//  Set, test and clear run decode, read and modify; range errors and unknown
//  codes go from decode straight to the result. Clear of the highest bit adds
//  a byte-per-cycle scan. Fill and clear-all sweep every byte; clear-above
//  runs a read-modify-write of the boundary byte if it is in the store, a
//  sweep of any bytes above it, then a scan. The store has one write port and
//  one registered read port. Reset leaves the store empty at once (valid bit
//  per byte) and bytes_in_use at 32; done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module bitmap_with_highest_set_tracking #(
    parameter int MAX_BYTES = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] req_type,
    input  wire logic [8:0] position,
    input  wire logic       cfg_we,
    input  wire logic [5:0] bytes_in_use,
    output logic            done,
    output logic            bit_was_set,
    output logic [8:0]      highest_set,
    output logic            range_error
);

    bmhs_pkg::cmd_t    cmd;
    bmhs_pkg::status_t status;

    bmhs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    bmhs_datapath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .position     (position),
        .cfg_we       (cfg_we),
        .bytes_in_use (bytes_in_use),
        .cmd          (cmd),
        .status       (status),
        .bit_was_set  (bit_was_set),
        .highest_set  (highest_set),
        .range_error  (range_error)
    );

endmodule
`default_nettype wire
